### sv/tcms_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcms_pkg
// Shared constants and types for the three-channel moving sum block.
// ----------------------------------------------------------------------------
package tcms_pkg;

  // Window length of the boxcar, in samples per channel
  localparam int unsigned WindowDepth      = 16;
  // Completed rounds between two calculation triggers
  localparam int unsigned RoundsPerTrigger = 8;
  // Converter resolution
  localparam int unsigned SampleBits       = 10;
  // Width of one running sum
  localparam int unsigned SumBits          = 14;
  localparam int unsigned NumChannels      = 3;

  localparam int unsigned ChanBits  = 2;
  localparam int unsigned SlotBits  = $clog2(WindowDepth);
  localparam int unsigned RndBits   = (RoundsPerTrigger > 1) ? $clog2(RoundsPerTrigger) : 1;
  localparam int unsigned RingDepth = NumChannels * WindowDepth;
  localparam int unsigned AddrBits  = $clog2(RingDepth);

  // Channel codes
  localparam logic [ChanBits-1:0] Chan0    = 2'd0;
  localparam logic [ChanBits-1:0] Chan1    = 2'd1;
  localparam logic [ChanBits-1:0] Chan2    = 2'd2;
  // Spare code, not reachable from reset
  localparam logic [ChanBits-1:0] ChanNone = 2'd3;

  typedef logic [SampleBits-1:0] sample_t;
  typedef logic [SumBits-1:0]    sum_t;
  typedef logic [AddrBits-1:0]   addr_t;

  // Sequencer decision for the transaction being taken
  typedef struct packed {
    logic                upd;     // sample updates a channel
    logic [ChanBits-1:0] ch;      // channel of this sample
    logic [SlotBits-1:0] slot;    // ring slot written
    logic [ChanBits-1:0] nxt_ch;  // channel after this transaction
    logic                trig;    // round counter wraps
  } ctrl_t;

endpackage

### sv/tcms_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcms_in_if / tcms_out_if
// Valid/ready channels carrying samples in and moving sums out.
// ----------------------------------------------------------------------------
interface tcms_in_if;
  logic                   valid;
  logic                   ready;
  tcms_pkg::sample_t      sample;
  logic                   results_locked;
  logic                   delta_locked;

  modport source (output valid, output sample, output results_locked,
                  output delta_locked, input ready);
  modport sink   (input valid, input sample, input results_locked,
                  input delta_locked, output ready);
endinterface

interface tcms_out_if;
  logic                          valid;
  logic                          ready;
  logic                          accepted;
  logic [tcms_pkg::ChanBits-1:0] next_channel;
  tcms_pkg::sum_t                sum_ch0;
  tcms_pkg::sum_t                sum_ch1;
  tcms_pkg::sum_t                sum_ch2;
  logic                          calc_trigger;

  modport source (output valid, output accepted, output next_channel,
                  output sum_ch0, output sum_ch1, output sum_ch2,
                  output calc_trigger, input ready);
  modport sink   (input valid, input accepted, input next_channel,
                  input sum_ch0, input sum_ch1, input sum_ch2,
                  input calc_trigger, output ready);
endinterface

### sv/tcms_ring_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcms_ring_mem
// Sample ring: single write port, one synchronous read port, with an entry
// valid flag so that entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module tcms_ring_mem (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               rd_en_i,
  input  tcms_pkg::addr_t    rd_addr_i,
  output tcms_pkg::sample_t  rd_data_o,
  input  logic               wr_en_i,
  input  tcms_pkg::addr_t    wr_addr_i,
  input  tcms_pkg::sample_t  wr_data_i
);

  tcms_pkg::sample_t                   mem_q [tcms_pkg::RingDepth];
  logic [tcms_pkg::RingDepth-1:0]      vld_q;
  tcms_pkg::sample_t                   rd_data_q;
  logic                                rd_vld_q;

  // Storage array, no reset
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  // Entry valid flags, cleared at reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rd_vld_q ? rd_data_q : '0;

endmodule

### sv/tcms_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcms_ctrl
// Channel sequencer: round-robin channel, shared ring slot and round count.
// ----------------------------------------------------------------------------
module tcms_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            take_i,
  input  logic            results_locked_i,
  input  logic            delta_locked_i,
  output tcms_pkg::ctrl_t ctrl_o
);

  logic [tcms_pkg::ChanBits-1:0] ch_q, ch_d;
  logic [tcms_pkg::SlotBits-1:0] slot_q, slot_d;
  logic [tcms_pkg::RndBits-1:0]  rnd_q, rnd_d;
  logic                          upd;
  logic                          trig;

  // Decide whether the sample counts and where the sequence goes next
  always_comb begin
    upd    = !results_locked_i && (ch_q != tcms_pkg::ChanNone) &&
             !((ch_q == tcms_pkg::Chan2) && delta_locked_i);
    ch_d   = ch_q;
    slot_d = slot_q;
    rnd_d  = rnd_q;
    trig   = 1'b0;
    if (upd) begin
      if (ch_q == tcms_pkg::Chan2) begin
        ch_d   = tcms_pkg::Chan0;
        slot_d = (slot_q == tcms_pkg::SlotBits'(tcms_pkg::WindowDepth - 1)) ?
                 '0 : slot_q + 1'b1;
        if (rnd_q == tcms_pkg::RndBits'(tcms_pkg::RoundsPerTrigger - 1)) begin
          rnd_d = '0;
          trig  = 1'b1;
        end else begin
          rnd_d = rnd_q + 1'b1;
        end
      end else begin
        ch_d = ch_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ch_q   <= tcms_pkg::Chan0;
      slot_q <= '0;
      rnd_q  <= '0;
    end else if (take_i) begin
      ch_q   <= ch_d;
      slot_q <= slot_d;
      rnd_q  <= rnd_d;
    end
  end

  assign ctrl_o.upd    = upd;
  assign ctrl_o.ch     = ch_q;
  assign ctrl_o.slot   = slot_q;
  assign ctrl_o.nxt_ch = ch_d;
  assign ctrl_o.trig   = trig;

endmodule

### sv/three_channel_moving_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// three_channel_moving_sum
// Round-robin 16-sample boxcar sum over three converter channels.
// ----------------------------------------------------------------------------
// Usage:
//   in_i carries one converter sample per transaction for the channel the
//   block selected last (next_channel of the previous result, 0 after reset),
//   with the results-lock and delta-lock flags. out_o returns one result per
//   input transaction: accepted flag, next channel, the three running sums
//   and the calculation trigger (every eighth completed round).
//   A taken input transaction loads the update stage; the result is offered
//   from the output register. The sample ring is read at the input edge
//   (synchronous RAM); when the update stage advances, the sum is updated,
//   the entry written back and the result registered.
//   Throughput: one transaction per cycle unless out_o stalls; successive
//   updates always hit other channels, so ring read and write never collide.
//   Reset clears the channel, slot, round count, running sums and the ring
//   entry flags; the ring reads as zero until written. No clearing pass.
//   When the receiver stalls, the result stays in the output register and the
//   update stage holds one more transaction before in_i.ready drops.
// ----------------------------------------------------------------------------
module three_channel_moving_sum (
  input  logic       clk_i,
  input  logic       rst_ni,
  tcms_in_if.sink    in_i,
  tcms_out_if.source out_o
);

  tcms_pkg::ctrl_t               ctrl;
  logic                          in_take;
  logic                          s1_adv;
  tcms_pkg::addr_t               rd_addr;
  tcms_pkg::sample_t             old_smp;
  tcms_pkg::sum_t                new_sum;
  logic                          wr_en;

  logic                          s1_valid_q;
  logic                          s1_upd_q;
  logic [tcms_pkg::ChanBits-1:0] s1_ch_q;
  tcms_pkg::addr_t               s1_addr_q;
  tcms_pkg::sample_t             s1_smp_q;
  logic [tcms_pkg::ChanBits-1:0] s1_nxt_q;
  logic                          s1_trig_q;

  tcms_pkg::sum_t                sum_q [tcms_pkg::NumChannels];
  tcms_pkg::sum_t                sum_d [tcms_pkg::NumChannels];

  logic                          out_valid_q;
  logic                          out_acc_q;
  logic [tcms_pkg::ChanBits-1:0] out_nxt_q;
  tcms_pkg::sum_t                out_sum0_q, out_sum1_q, out_sum2_q;
  logic                          out_trig_q;

  // Handshake
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_take    = in_i.valid && in_i.ready;

  tcms_ctrl u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .take_i          (in_take),
    .results_locked_i(in_i.results_locked),
    .delta_locked_i  (in_i.delta_locked),
    .ctrl_o          (ctrl)
  );

  // Ring address: channel block plus shared slot
  assign rd_addr = tcms_pkg::AddrBits'(ctrl.ch) *
                   tcms_pkg::AddrBits'(tcms_pkg::WindowDepth) +
                   tcms_pkg::AddrBits'(ctrl.slot);

  assign wr_en = s1_adv && s1_upd_q;

  tcms_ring_mem u_ring (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .rd_en_i  (in_take && ctrl.upd),
    .rd_addr_i(rd_addr),
    .rd_data_o(old_smp),
    .wr_en_i  (wr_en),
    .wr_addr_i(s1_addr_q),
    .wr_data_i(s1_smp_q)
  );

  // Update stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      s1_valid_q <= in_i.valid;
    end
  end

  // Update stage payload
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_upd_q  <= ctrl.upd;
      s1_ch_q   <= ctrl.ch;
      s1_addr_q <= rd_addr;
      s1_smp_q  <= in_i.sample;
      s1_nxt_q  <= ctrl.nxt_ch;
      s1_trig_q <= ctrl.trig;
    end
  end

  // Running sum: drop the oldest sample, add the new one
  always_comb begin
    new_sum = '0;
    for (int i = 0; i < tcms_pkg::NumChannels; i++) begin
      sum_d[i] = sum_q[i];
    end
    unique case (s1_ch_q)
      tcms_pkg::Chan0: new_sum = sum_q[0];
      tcms_pkg::Chan1: new_sum = sum_q[1];
      tcms_pkg::Chan2: new_sum = sum_q[2];
      default:         new_sum = '0;
    endcase
    new_sum = new_sum - tcms_pkg::SumBits'(old_smp) + tcms_pkg::SumBits'(s1_smp_q);
    if (s1_upd_q) begin
      unique case (s1_ch_q)
        tcms_pkg::Chan0: sum_d[0] = new_sum;
        tcms_pkg::Chan1: sum_d[1] = new_sum;
        tcms_pkg::Chan2: sum_d[2] = new_sum;
        default:         ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < tcms_pkg::NumChannels; i++) begin
        sum_q[i] <= '0;
      end
    end else if (s1_adv) begin
      for (int i = 0; i < tcms_pkg::NumChannels; i++) begin
        sum_q[i] <= sum_d[i];
      end
    end
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_adv) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_acc_q  <= s1_upd_q;
      out_nxt_q  <= s1_nxt_q;
      out_sum0_q <= sum_d[0];
      out_sum1_q <= sum_d[1];
      out_sum2_q <= sum_d[2];
      out_trig_q <= s1_trig_q;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.accepted     = out_acc_q;
  assign out_o.next_channel = out_nxt_q;
  assign out_o.sum_ch0      = out_sum0_q;
  assign out_o.sum_ch1      = out_sum1_q;
  assign out_o.sum_ch2      = out_sum2_q;
  assign out_o.calc_trigger = out_trig_q;

  // Ring read and write-back never address the same entry in one cycle
  a_no_collision: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_en && in_take && ctrl.upd) |-> (s1_addr_q != rd_addr))
    else $error("ring read and write-back collide");

  // A trigger only comes with an accepted channel-2 sample
  a_trig_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.calc_trigger) |->
      (out_o.accepted && (out_o.next_channel == tcms_pkg::Chan0)))
    else $error("trigger without completed round");

  // A taken transaction occupies the update stage next cycle
  a_s1_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_take |=> s1_valid_q)
    else $error("update stage lost a transaction");

  // A stalled update stage keeps its sum state
  a_sum_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (sum_q[0] == $past(sum_q[0]) &&
      sum_q[1] == $past(sum_q[1]) && sum_q[2] == $past(sum_q[2])))
    else $error("sums changed during stall");

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking testbench for the three-channel moving sum block.
// A queue of sample transactions, first a short directed sequence and then
// random ones, is driven on the input channel with random gaps. Every input
// transaction is run through a local model of the round-robin boxcar sums.
// Each output transaction is compared field by field with the oldest
// prediction. Both sides idle at random. The receiver holds off once for a
// long stretch, and the sender drains the block twice before going on.
// ----------------------------------------------------------------------------
module tb_top;

  // One sample transaction, plus a flag that makes the sender wait
  // until every outstanding result has arrived
  typedef struct {
    tcms_pkg::sample_t sample;
    logic              results_locked;
    logic              delta_locked;
    logic              drain_first;
  } sample_item_t;

  // One predicted result
  typedef struct {
    logic                          accepted;
    logic [tcms_pkg::ChanBits-1:0] next_channel;
    tcms_pkg::sum_t                sum_ch0;
    tcms_pkg::sum_t                sum_ch1;
    tcms_pkg::sum_t                sum_ch2;
    logic                          calc_trigger;
  } sums_result_t;

  localparam int unsigned IdlePercent = 27;
  localparam int unsigned HoldOffAt   = 150;
  localparam int unsigned HoldOffLen  = 150;
  localparam int unsigned BusyFrom    = 300;
  localparam int unsigned BusyTo      = 420;
  localparam int unsigned RandomItems = 500;
  localparam int unsigned TailCycles  = 10;

  logic clk_i;
  logic rst_ni;

  tcms_in_if  in_if ();
  tcms_out_if out_if ();

  three_channel_moving_sum dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  sample_item_t pending_samples[$];
  sums_result_t expected_sums[$];

  // Model state of the block
  tcms_pkg::sample_t             ring_model[tcms_pkg::RingDepth];
  tcms_pkg::sum_t                sums_model[tcms_pkg::NumChannels];
  logic [tcms_pkg::ChanBits-1:0] chan_model;
  int unsigned                   slot_model;
  int unsigned                   rounds_model;

  int unsigned mismatch_count;
  int unsigned samples_taken;
  bit          sample_taken_now;
  int unsigned hold_off_left;
  bit          hold_off_done;

  // Clock
  always begin
    clk_i = 1'b0;
    #4;
    clk_i = 1'b1;
    #4;
  end

  // Model of one sample transaction: ring update, sums, channel and trigger
  function automatic sums_result_t step_sums(input sample_item_t it);
    sums_result_t                  res;
    logic [tcms_pkg::ChanBits-1:0] ch;
    int unsigned                   pos;
    ch               = chan_model;
    res.accepted     = 1'b0;
    res.calc_trigger = 1'b0;
    if (!it.results_locked && ch <= tcms_pkg::Chan2 &&
        !(ch == tcms_pkg::Chan2 && it.delta_locked)) begin
      pos             = ch * tcms_pkg::WindowDepth + slot_model;
      sums_model[ch]  = sums_model[ch] - tcms_pkg::sum_t'(ring_model[pos]) +
                        tcms_pkg::sum_t'(it.sample);
      ring_model[pos] = it.sample;
      res.accepted    = 1'b1;
      if (ch == tcms_pkg::Chan2) begin
        chan_model   = tcms_pkg::Chan0;
        slot_model   = (slot_model + 1) % tcms_pkg::WindowDepth;
        rounds_model = rounds_model + 1;
        if (rounds_model >= tcms_pkg::RoundsPerTrigger) begin
          rounds_model     = 0;
          res.calc_trigger = 1'b1;
        end
      end else begin
        chan_model = ch + 1'b1;
      end
    end
    res.next_channel = chan_model;
    res.sum_ch0      = sums_model[0];
    res.sum_ch1      = sums_model[1];
    res.sum_ch2      = sums_model[2];
    return res;
  endfunction

  task automatic check_field(input string name, input int unsigned exp_v,
                             input int unsigned act_v);
    if (exp_v != act_v) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
      mismatch_count++;
    end
  endtask

  task automatic add_item(input int unsigned smp, input bit rl, input bit dl,
                          input bit drain);
    sample_item_t it;
    it.sample         = tcms_pkg::sample_t'(smp);
    it.results_locked = rl;
    it.delta_locked   = dl;
    it.drain_first    = drain;
    pending_samples.push_back(it);
  endtask

  // Monitor: check output transactions, then predict input transactions
  always @(posedge clk_i) begin
    sums_result_t exp_r;
    if (out_if.valid && out_if.ready) begin
      if (expected_sums.size() == 0) begin
        $display("%0t ns: unexpected result transaction", $time);
        mismatch_count++;
      end else begin
        exp_r = expected_sums.pop_front();
        check_field("accepted", exp_r.accepted, out_if.accepted);
        check_field("next_channel", exp_r.next_channel, out_if.next_channel);
        check_field("sum_ch0", exp_r.sum_ch0, out_if.sum_ch0);
        check_field("sum_ch1", exp_r.sum_ch1, out_if.sum_ch1);
        check_field("sum_ch2", exp_r.sum_ch2, out_if.sum_ch2);
        check_field("calc_trigger", exp_r.calc_trigger, out_if.calc_trigger);
      end
    end
    if (in_if.valid && in_if.ready) begin
      sample_item_t seen;
      seen.sample         = in_if.sample;
      seen.results_locked = in_if.results_locked;
      seen.delta_locked   = in_if.delta_locked;
      seen.drain_first    = 1'b0;
      expected_sums.push_back(step_sums(seen));
      samples_taken++;
      sample_taken_now = 1'b1;
    end
  end

  // Driver: offer the next sample once the previous transaction has gone
  always @(negedge clk_i) begin
    bool_idle_blk : begin
      bit idle;
      idle = ($urandom_range(99) < IdlePercent) &&
             !(samples_taken >= BusyFrom && samples_taken < BusyTo);
      if (rst_ni && (!in_if.valid || sample_taken_now)) begin
        sample_taken_now = 1'b0;
        if (pending_samples.size() == 0 || idle ||
            (pending_samples[0].drain_first && expected_sums.size() != 0)) begin
          in_if.valid <= 1'b0;
        end else begin
          in_if.valid          <= 1'b1;
          in_if.sample         <= pending_samples[0].sample;
          in_if.results_locked <= pending_samples[0].results_locked;
          in_if.delta_locked   <= pending_samples[0].delta_locked;
          void'(pending_samples.pop_front());
        end
      end
    end
  end

  // Receiver: random back-pressure, with one long hold-off
  always @(negedge clk_i) begin
    if (!hold_off_done && samples_taken >= HoldOffAt) begin
      hold_off_done = 1'b1;
      hold_off_left = HoldOffLen;
    end
    if (!rst_ni) begin
      out_if.ready <= 1'b0;
    end else if (hold_off_left > 0) begin
      hold_off_left--;
      out_if.ready <= 1'b0;
    end else if (samples_taken >= BusyFrom && samples_taken < BusyTo) begin
      out_if.ready <= 1'b1;
    end else begin
      out_if.ready <= ($urandom_range(99) >= IdlePercent);
    end
  end

  // Stimulus, reset and end of run
  initial begin
    int unsigned pick;
    int unsigned smp;
    in_if.valid          = 1'b0;
    in_if.sample         = '0;
    in_if.results_locked = 1'b0;
    in_if.delta_locked   = 1'b0;
    out_if.ready         = 1'b0;
    mismatch_count       = 0;
    samples_taken        = 0;
    sample_taken_now     = 1'b0;
    hold_off_left        = 0;
    hold_off_done        = 1'b0;
    foreach (ring_model[i]) ring_model[i] = '0;
    foreach (sums_model[i]) sums_model[i] = '0;
    chan_model   = tcms_pkg::Chan0;
    slot_model   = 0;
    rounds_model = 0;
    rst_ni       = 1'b0;

    // Directed: extremes, each lock alone and both together, delta lock held on ch2
    add_item(1023, 0, 0, 0);  // ch0 full scale
    add_item(0,    0, 0, 0);  // ch1 zero
    add_item(1023, 0, 0, 0);  // ch2, slot advances
    add_item(555,  1, 0, 0);  // results lock on ch0: skipped
    add_item(512,  0, 1, 0);  // delta lock on ch0: no effect
    add_item(3,    1, 1, 0);  // both locks on ch1: skipped
    add_item(1,    0, 0, 0);  // ch1
    add_item(1000, 0, 1, 0);  // delta lock on ch2: stays on ch2
    add_item(7,    1, 0, 0);  // results lock on ch2
    add_item(9,    1, 1, 0);  // both locks on ch2
    add_item(682,  0, 0, 0);  // ch2 taken at last
    add_item(341,  0, 0, 1);  // sender waits for the block to drain first
    add_item(1023, 0, 0, 0);
    add_item(0,    0, 0, 0);

    // Random: mostly accepted samples, a full-scale stretch then a zero one
    for (int unsigned n = 0; n < RandomItems; n++) begin
      if (n >= 100 && n < 160) begin
        add_item(1023, 0, 0, 0);
      end else if (n >= 160 && n < 220) begin
        add_item(0, 0, 0, 0);
      end else begin
        pick = $urandom_range(9);
        if (pick == 0) smp = 0;
        else if (pick == 1) smp = 1023;
        else smp = $urandom_range(1023);
        add_item(smp, $urandom_range(7) == 0, $urandom_range(3) == 0, n == 250);
      end
    end

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Wait for all stimulus, then for every result, then a short tail
    while (pending_samples.size() != 0 || in_if.valid) @(posedge clk_i);
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (TailCycles) @(posedge clk_i);
    if (expected_sums.size() != 0) begin
      $display("%0t ns: %0d results never arrived", $time, expected_sums.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #1ms;
    $display("%0t ns: timeout", $time);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

### files.f
sv/tcms_pkg.sv
sv/tcms_if.sv
sv/tcms_ring_mem.sv
sv/tcms_ctrl.sv
sv/three_channel_moving_sum.sv
tb/tb_top.sv
